>>> src/pfbf_pkg.sv
// ----------------------------------------------------------------------------
// pfbf_pkg
// Shared widths and stream word layouts for the page frame buffer box fill.
// ----------------------------------------------------------------------------
package pfbf_pkg;

  localparam int BYTE_W     = 8;
  localparam int X_FIELD_W  = 6;
  localparam int Y_FIELD_W  = 5;
  localparam int BW_FIELD_W = 7;
  localparam int BH_FIELD_W = 6;
  localparam int PG_FIELD_W = 2;
  localparam int COL_FIELD_W = 6;
  localparam int COORD_W    = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [4:0]            pad;
    logic [PG_FIELD_W-1:0] page;
    logic                  fill_value;
    logic [BH_FIELD_W-1:0] box_height;
    logic [BW_FIELD_W-1:0] box_width;
    logic [Y_FIELD_W-1:0]  y_start;
    logic [X_FIELD_W-1:0]  x_start;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             pad;
    logic [COL_FIELD_W-1:0] column;
    logic [BYTE_W-1:0]      column_byte;
  } out_word_t;

endpackage

>>> src/pfbf_mem.sv
// ----------------------------------------------------------------------------
// pfbf_mem
// Simple dual-port byte store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfbf_mem
  import pfbf_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/page_framebuffer_box_fill.sv
// ----------------------------------------------------------------------------
// page_framebuffer_box_fill
// Monochrome page frame buffer: rectangle set/clear inside the border and
// page read-out as a stream of column bytes.
//
// channel  dir  tdata                          tuser/tlast
// s_axis   in   x,y,width,height,fill,page     tuser = func
// m_axis   out  column_byte,column             tlast = last byte of page
//
// After reset a sweep writes the border image with s_axis_tready low.
// Paint: a read-modify-write of each column byte touched (columns x pages).
// Read: one column byte at a time through the registered memory read, the
// next issued only once the last has left it; m_axis stalls hold the read
// sequencer.
// ----------------------------------------------------------------------------
module page_framebuffer_box_fill
  import pfbf_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 64,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x_start[5:0] y_start[10:6] box_width[17:11] box_height[23:18]
  // fill_value[24] page[26:25]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // column_byte[7:0] column[13:8]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int PAGES = SCREEN_HEIGHT / 8;
  localparam int DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(SCREEN_WIDTH);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_WIDTH - 2);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_HEIGHT - 2);
  localparam logic [CW-1:0]      COL_LAST  = CW'(SCREEN_WIDTH - 1);
  localparam logic [PW-1:0]      PAGE_LAST = PW'(PAGES - 1);
  localparam logic [AW-1:0]      ROW_STEP  = AW'(SCREEN_WIDTH);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PAINT = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  function automatic logic [PW-1:0] page_wrap(input logic [PG_FIELD_W-1:0] p);
    int v;
    v = int'(p);
    for (int i = 0; i < 3; i++) begin
      if (v >= PAGES) begin
        v = v - PAGES;
      end
    end
    return PW'(v);
  endfunction

  logic [1:0]        state;
  logic [PW-1:0]     pg;
  logic [CW-1:0]     col;
  logic [AW-1:0]     base;
  logic [CW-1:0]     xlo;
  logic [CW-1:0]     xhi;
  logic [PW-1:0]     pg_lo;
  logic [PW-1:0]     pg_hi;
  logic [2:0]        bit_lo;
  logic [2:0]        bit_hi;
  logic              fill;
  logic              wb_valid;
  logic [AW-1:0]     wb_addr;
  logic [BYTE_W-1:0] wb_mask;
  logic              wb_fill;
  logic              pending;
  logic [CW-1:0]     pend_col;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [CW-1:0]     out_col;
  logic              out_last;

  in_word_t          in_word;
  out_word_t         out_word;
  logic              accept;
  logic [COORD_W-1:0] x0, y0, bw, bh, xend, yend, xlo_c, xhi_c, ylo_c, yhi_c;
  logic              box_empty;
  logic [PW-1:0]     ylo_pg, yhi_pg, rd_pg;
  logic [2:0]        lo_b, hi_b;
  logic [BYTE_W-1:0] page_mask;
  logic [BYTE_W-1:0] init_byte;
  logic              issue;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  assign in_word = in_word_t'(s_axis_tdata);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // clip rectangle to the interior
  always_comb begin
    x0 = COORD_W'(in_word.x_start);
    y0 = COORD_W'(in_word.y_start);
    bw = COORD_W'(in_word.box_width);
    bh = COORD_W'(in_word.box_height);
    xend = x0 + bw - COORD_W'(1);
    yend = y0 + bh - COORD_W'(1);
    xlo_c = (x0 == '0) ? COORD_W'(1) : x0;
    ylo_c = (y0 == '0) ? COORD_W'(1) : y0;
    xhi_c = (xend > X_MAX) ? X_MAX : xend;
    yhi_c = (yend > Y_MAX) ? Y_MAX : yend;
    box_empty = (bw == '0) || (bh == '0) || (xlo_c > xhi_c) || (ylo_c > yhi_c);
    ylo_pg = PW'(ylo_c >> 3);
    yhi_pg = PW'(yhi_c >> 3);
    rd_pg  = page_wrap(in_word.page);
  end

  always_comb begin
    lo_b = (pg == pg_lo) ? bit_lo : 3'd0;
    hi_b = (pg == pg_hi) ? bit_hi : 3'd7;
    page_mask = (8'hFF << lo_b) & (8'hFF >> (3'd7 - hi_b));
  end

  always_comb begin
    init_byte = '0;
    if (pg == '0) begin
      init_byte[0] = 1'b1;
    end
    if (pg == PAGE_LAST) begin
      init_byte[BYTE_W-1] = 1'b1;
    end
    if ((col == '0) || (col == COL_LAST)) begin
      init_byte = 8'd255;
    end
  end

  assign issue = (state == ST_READ) && !pending && (!out_valid || m_axis_tready);

  always_comb begin
    mem_raddr = base + AW'(col);
    mem_re    = (state == ST_PAINT) || issue;
    if (state == ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = base + AW'(col);
      mem_wdata = init_byte;
    end else begin
      mem_we    = wb_valid;
      mem_waddr = wb_addr;
      mem_wdata = wb_fill ? (mem_rdata | wb_mask) : (mem_rdata & ~wb_mask);
    end
  end

  pfbf_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      pg       <= '0;
      col      <= '0;
      base     <= '0;
      wb_valid <= 1'b0;
      pending  <= 1'b0;
    end else begin
      wb_valid <= 1'b0;
      pending  <= issue;
      case (state)
        ST_INIT: begin
          if (col == COL_LAST) begin
            col  <= '0;
            pg   <= pg + PW'(1);
            base <= base + ROW_STEP;
            if (pg == PAGE_LAST) begin
              state <= ST_IDLE;
            end
          end else begin
            col <= col + CW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              state <= ST_READ;
              col   <= '0;
              base  <= AW'(AW'(rd_pg) * ROW_STEP);
            end else if (!box_empty) begin
              state <= ST_PAINT;
              col   <= CW'(xlo_c);
              pg    <= ylo_pg;
              base  <= AW'(AW'(ylo_pg) * ROW_STEP);
            end
          end
        end
        ST_PAINT: begin
          wb_valid <= 1'b1;
          if (col == xhi) begin
            col  <= xlo;
            pg   <= pg + PW'(1);
            base <= base + ROW_STEP;
            if (pg == pg_hi) begin
              state <= ST_IDLE;
            end
          end else begin
            col <= col + CW'(1);
          end
        end
        ST_READ: begin
          if (issue) begin
            if (col == COL_LAST) begin
              state <= ST_IDLE;
            end else begin
              col <= col + CW'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xlo    <= CW'(xlo_c);
      xhi    <= CW'(xhi_c);
      pg_lo  <= ylo_pg;
      pg_hi  <= yhi_pg;
      bit_lo <= ylo_c[2:0];
      bit_hi <= yhi_c[2:0];
      fill   <= in_word.fill_value;
    end
    wb_addr  <= mem_raddr;
    wb_mask  <= page_mask;
    wb_fill  <= fill;
    pend_col <= col;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pending) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      out_byte <= mem_rdata;
      out_col  <= pend_col;
      out_last <= (pend_col == COL_LAST);
    end
  end

  always_comb begin
    out_word             = '0;
    out_word.column_byte = out_byte;
    out_word.column      = COL_FIELD_W'(out_col);
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;
  assign m_axis_tlast  = out_last;

endmodule
